/* sv/vrt_pkg.sv */
package vrt_pkg;

	localparam int GRID_BITS        = 5;
	localparam int ORIGIN_FRAC_BITS = 10;

	localparam int GRID_SIZE = 1 << GRID_BITS;
	localparam int ROW_BITS  = 2 * GRID_BITS;
	localparam int ROW_COUNT = 1 << ROW_BITS;

	localparam int ORG_W   = 16;
	localparam int DIR_W   = 16;
	localparam int COORD_W = 5;
	localparam int STEP_W  = 8;
	// cell coordinate: origin integer part plus up to 255 unit steps
	localparam int POS_W   = 26 - ORIGIN_FRAC_BITS;

	localparam int TIME_W    = 32;
	localparam int NUM_W     = 31;
	localparam int DEN_W     = 16;
	localparam int DIV_SHIFT = 30 - ORIGIN_FRAC_BITS;
	localparam int DCNT_W    = $clog2(NUM_W);

	localparam logic [TIME_W-1:0] TIME_INF = '1;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_RAY   = 1'b1;

	localparam logic [1:0] AXIS_X    = 2'd0;
	localparam logic [1:0] AXIS_Y    = 2'd1;
	localparam logic [1:0] AXIS_Z    = 2'd2;
	localparam logic [1:0] AXIS_NONE = 2'd3;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WR_RD,
		ST_WR_WB,
		ST_DIV_START,
		ST_DIV_WAIT,
		ST_STEP,
		ST_TEST,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic                   start;
		logic [NUM_W-1:0]       num;
		logic [DEN_W-1:0]       den;
	} div_req_t;

endpackage

/* sv/vrt_if.sv */
interface vrt_item_if;
	logic                     valid;
	logic                     ready;
	logic                     op;
	logic [4:0]               voxel_x;
	logic [4:0]               voxel_y;
	logic [4:0]               voxel_z;
	logic                     solid;
	logic signed [15:0]       origin_x;
	logic signed [15:0]       origin_y;
	logic signed [15:0]       origin_z;
	logic signed [15:0]       dir_x;
	logic signed [15:0]       dir_y;
	logic signed [15:0]       dir_z;
	logic [7:0]               max_steps;

	modport source (output valid, op, voxel_x, voxel_y, voxel_z, solid, origin_x, origin_y,
		origin_z, dir_x, dir_y, dir_z, max_steps, input ready);
	modport sink (input valid, op, voxel_x, voxel_y, voxel_z, solid, origin_x, origin_y,
		origin_z, dir_x, dir_y, dir_z, max_steps, output ready);
endinterface

interface vrt_result_if;
	logic       valid;
	logic       ready;
	logic       hit;
	logic [4:0] hit_x;
	logic [4:0] hit_y;
	logic [4:0] hit_z;
	logic [1:0] normal_axis;
	logic       normal_negative;
	logic [7:0] steps_used;

	modport source (output valid, hit, hit_x, hit_y, hit_z, normal_axis, normal_negative,
		steps_used, input ready);
	modport sink (input valid, hit, hit_x, hit_y, hit_z, normal_axis, normal_negative,
		steps_used, output ready);
endinterface

/* sv/vrt_ram.sv */
module vrt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

/* sv/vrt_div.sv */
module vrt_div
	import vrt_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  div_req_t         req,
	output logic             done,
	output logic [NUM_W-1:0] quo
);
	logic              busy_q;
	logic              done_q;
	logic [DCNT_W-1:0] cnt_q;
	logic [DEN_W-1:0]  rem_q;
	logic [NUM_W-1:0]  quo_q;
	logic [DEN_W-1:0]  den_q;
	logic [DEN_W:0]    part;
	logic [DEN_W:0]    trial;

	// restoring radix-2, one quotient bit per cycle
	assign part  = {rem_q, quo_q[NUM_W-1]};
	assign trial = part - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= DCNT_W'(NUM_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.num;
			den_q <= req.den;
		end else if (busy_q) begin
			if (!trial[DEN_W]) begin
				rem_q <= trial[DEN_W-1:0];
				quo_q <= {quo_q[NUM_W-2:0], 1'b1};
			end else begin
				rem_q <= part[DEN_W-1:0];
				quo_q <= {quo_q[NUM_W-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
endmodule

/* sv/voxel_ray_traversal.sv */
// Voxel write: after acceptance the row is read, then written back, and item.ready returns.
// Ray: six divisions in turn on the shared 31-step divider (ST_DIV_START, then ST_DIV_WAIT),
//   ST_STEP/ST_TEST per cell, a last ST_STEP if max_steps ends it, ST_DONE to the result.
// One transaction in flight; a held result does not block the next input.
// After arst_n the occupancy RAM is cleared one row a cycle (all 1024 rows), item.ready low.
module voxel_ray_traversal
	import vrt_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	vrt_item_if.sink     item,
	vrt_result_if.source result
);
	state_t state_q, state_d;

	// occupancy RAM: one row of voxels along x per (z, y)
	logic                 ram_we;
	logic [ROW_BITS-1:0]  ram_addr;
	logic [GRID_SIZE-1:0] ram_wdata;
	logic [GRID_SIZE-1:0] ram_rdata;

	vrt_ram #(.WIDTH(GRID_SIZE), .DEPTH(ROW_COUNT)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	div_req_t         div_req;
	logic             div_done;
	logic [NUM_W-1:0] div_quo;

	vrt_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.done   (div_done),
		.quo    (div_quo)
	);

	logic [ROW_BITS-1:0] clr_q;

	// voxel write transaction
	logic                 vin_q;
	logic [GRID_BITS-1:0] vx_q;
	logic [ROW_BITS-1:0]  vrow_q;
	logic                 solid_q;

	// ray state, one entry per axis
	logic signed [ORG_W-1:0] org_q    [3];
	logic                    dneg_q   [3];
	logic                    dzero_q  [3];
	logic [DEN_W-1:0]        mag_q    [3];
	logic signed [POS_W-1:0] pos_q    [3];
	logic [TIME_W-1:0]       tmax_q   [3];
	logic [TIME_W-1:0]       tdelta_q [3];
	logic [STEP_W-1:0]       limit_q;
	logic [STEP_W-1:0]       used_q;
	logic [1:0]              axis_q;
	logic                    neg_q;
	logic                    hit_q;
	logic [2:0]              div_idx_q;

	// result register
	logic              out_valid_q;
	logic              out_hit_q;
	logic [4:0]        out_x_q, out_y_q, out_z_q;
	logic [1:0]        out_axis_q;
	logic              out_neg_q;
	logic [STEP_W-1:0] out_used_q;

	logic accept;
	logic out_free;
	assign item.ready = (state_q == ST_IDLE);
	assign accept     = item.valid && item.ready;
	assign out_free   = !out_valid_q || result.ready;

	// divider operands: idx[2:1] is the axis, idx[0] picks crossing interval
	logic [1:0]                  div_ax;
	logic [ORIGIN_FRAC_BITS-1:0] frac;
	logic [ORIGIN_FRAC_BITS:0]   fdist;
	assign div_ax = div_idx_q[2:1];
	assign frac   = org_q[div_ax][ORIGIN_FRAC_BITS-1:0];
	assign fdist  = dneg_q[div_ax] ? {1'b0, frac}
		: ((ORIGIN_FRAC_BITS+1)'(1) << ORIGIN_FRAC_BITS) - {1'b0, frac};

	always_comb begin
		div_req.start = (state_q == ST_DIV_START);
		div_req.den   = mag_q[div_ax];
		if (div_idx_q[0]) begin
			div_req.num = NUM_W'(1) << 30;
		end else begin
			div_req.num = NUM_W'(fdist) << DIV_SHIFT;
		end
	end

	// walk datapath
	logic                in_grid;
	logic [ROW_BITS-1:0] pos_row;
	logic                cell_solid;
	logic [1:0]          sel;
	logic [TIME_W:0]     tsum;

	assign in_grid = (pos_q[0][POS_W-1:GRID_BITS] == '0) && (pos_q[1][POS_W-1:GRID_BITS] == '0)
		&& (pos_q[2][POS_W-1:GRID_BITS] == '0);
	assign pos_row = (ROW_BITS'(pos_q[2][GRID_BITS-1:0]) << GRID_BITS)
		| ROW_BITS'(pos_q[1][GRID_BITS-1:0]);
	assign cell_solid = in_grid && ram_rdata[pos_q[0][GRID_BITS-1:0]];

	// strictly smallest crossing; ties go to the later axis (y over x, z over x and y)
	always_comb begin
		priority if (tmax_q[0] < tmax_q[1] && tmax_q[0] < tmax_q[2]) begin
			sel = AXIS_X;
		end else if (tmax_q[1] < tmax_q[2]) begin
			sel = AXIS_Y;
		end else begin
			sel = AXIS_Z;
		end
	end
	assign tsum = {1'b0, tmax_q[sel]} + {1'b0, tdelta_q[sel]};

	// RAM port
	logic [GRID_SIZE-1:0] wb_row;
	always_comb begin
		wb_row              = ram_rdata;
		wb_row[vx_q]        = solid_q;
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_addr  = pos_row;
		ram_wdata = wb_row;
		unique case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_addr  = clr_q;
				ram_wdata = '0;
			end
			ST_WR_RD: begin
				ram_addr = vrow_q;
			end
			ST_WR_WB: begin
				ram_we   = 1'b1;
				ram_addr = vrow_q;
			end
			default: begin
				ram_addr = pos_row;
			end
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR:     if (clr_q == '1) state_d = ST_IDLE;
			ST_IDLE: begin
				if (accept) begin
					state_d = (item.op == OP_RAY) ? ST_DIV_START : ST_WR_RD;
				end
			end
			ST_WR_RD:     state_d = vin_q ? ST_WR_WB : ST_IDLE;
			ST_WR_WB:     state_d = ST_IDLE;
			ST_DIV_START: state_d = ST_DIV_WAIT;
			ST_DIV_WAIT: begin
				if (div_done) begin
					state_d = (div_idx_q == 3'd5) ? ST_STEP : ST_DIV_START;
				end
			end
			ST_STEP:      state_d = (used_q == limit_q) ? ST_DONE : ST_TEST;
			ST_TEST:      state_d = cell_solid ? ST_DONE : ST_STEP;
			ST_DONE:      if (out_free) state_d = ST_IDLE;
			default:      state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
		end
	end

	// item capture, setup and walk
	always_ff @(posedge clk) begin
		if (accept) begin
			vin_q   <= (int'(item.voxel_x) < GRID_SIZE) && (int'(item.voxel_y) < GRID_SIZE)
				&& (int'(item.voxel_z) < GRID_SIZE);
			vx_q    <= GRID_BITS'(item.voxel_x);
			vrow_q  <= (ROW_BITS'(item.voxel_z) << GRID_BITS) | ROW_BITS'(item.voxel_y);
			solid_q <= item.solid;
			org_q[0] <= item.origin_x;
			org_q[1] <= item.origin_y;
			org_q[2] <= item.origin_z;
			dneg_q[0] <= item.dir_x[DIR_W-1];
			dneg_q[1] <= item.dir_y[DIR_W-1];
			dneg_q[2] <= item.dir_z[DIR_W-1];
			dzero_q[0] <= (item.dir_x == '0);
			dzero_q[1] <= (item.dir_y == '0);
			dzero_q[2] <= (item.dir_z == '0);
			mag_q[0] <= item.dir_x[DIR_W-1] ? DEN_W'(-item.dir_x) : DEN_W'(item.dir_x);
			mag_q[1] <= item.dir_y[DIR_W-1] ? DEN_W'(-item.dir_y) : DEN_W'(item.dir_y);
			mag_q[2] <= item.dir_z[DIR_W-1] ? DEN_W'(-item.dir_z) : DEN_W'(item.dir_z);
			// floor of the origin is an arithmetic shift
			pos_q[0] <= POS_W'(item.origin_x >>> ORIGIN_FRAC_BITS);
			pos_q[1] <= POS_W'(item.origin_y >>> ORIGIN_FRAC_BITS);
			pos_q[2] <= POS_W'(item.origin_z >>> ORIGIN_FRAC_BITS);
			limit_q   <= item.max_steps;
			used_q    <= '0;
			axis_q    <= AXIS_NONE;
			neg_q     <= 1'b0;
			hit_q     <= 1'b0;
			div_idx_q <= '0;
		end

		if (state_q == ST_DIV_WAIT && div_done) begin
			div_idx_q <= div_idx_q + 1'b1;
			if (div_idx_q[0]) begin
				tdelta_q[div_ax] <= dzero_q[div_ax] ? TIME_INF : TIME_W'(div_quo);
			end else begin
				tmax_q[div_ax] <= dzero_q[div_ax] ? TIME_INF : TIME_W'(div_quo);
			end
		end

		if (state_q == ST_STEP && used_q != limit_q) begin
			used_q <= used_q + 1'b1;
		end

		if (state_q == ST_TEST) begin
			if (cell_solid) begin
				hit_q <= 1'b1;
			end else begin
				if (!dzero_q[sel]) begin
					pos_q[sel] <= dneg_q[sel] ? pos_q[sel] - 1'b1 : pos_q[sel] + 1'b1;
				end
				tmax_q[sel] <= tsum[TIME_W] ? TIME_INF : tsum[TIME_W-1:0];
				axis_q      <= sel;
				neg_q       <= !dzero_q[sel] && !dneg_q[sel];
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			out_hit_q  <= hit_q;
			out_x_q    <= hit_q ? pos_q[0][4:0] : '0;
			out_y_q    <= hit_q ? pos_q[1][4:0] : '0;
			out_z_q    <= hit_q ? pos_q[2][4:0] : '0;
			out_axis_q <= axis_q;
			out_neg_q  <= neg_q;
			out_used_q <= used_q;
		end
	end

	assign result.valid           = out_valid_q;
	assign result.hit             = out_hit_q;
	assign result.hit_x           = out_x_q;
	assign result.hit_y           = out_y_q;
	assign result.hit_z           = out_z_q;
	assign result.normal_axis     = out_axis_q;
	assign result.normal_negative = out_neg_q;
	assign result.steps_used      = out_used_q;

`ifndef SYNTHESIS
	a_clear_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> !item.ready)
		else $error("input taken during RAM clear");

	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_STEP || state_q == ST_TEST || state_q == ST_DONE) |-> (used_q <= limit_q))
		else $error("step count passed the limit");

	a_miss_coords: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && !result.hit) |->
		(result.hit_x == '0 && result.hit_y == '0 && result.hit_z == '0))
		else $error("miss reports nonzero cell");

	a_no_step_normal: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.normal_axis == AXIS_NONE) |-> !result.normal_negative)
		else $error("normal sign without a step");

	a_test_follows_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_TEST) |-> ($past(state_q) == ST_STEP))
		else $error("cell test without a RAM read");
`endif
endmodule

/* tb/sv/voxel_ray_traversal_tb_if.sv */
`timescale 1ns / 1ps

// Interfaces come from the RTL tree (sv/vrt_if.sv). This file only carries the
// transaction records used on both sides of the bench.
package vrt_tb_pkg;
	import vrt_pkg::*;

	typedef struct {
		logic              op;
		logic [4:0]        voxel_x;
		logic [4:0]        voxel_y;
		logic [4:0]        voxel_z;
		logic              solid;
		logic signed [15:0] origin_x;
		logic signed [15:0] origin_y;
		logic signed [15:0] origin_z;
		logic signed [15:0] dir_x;
		logic signed [15:0] dir_y;
		logic signed [15:0] dir_z;
		logic [7:0]        max_steps;
	} grid_cmd_t;

	typedef struct packed {
		logic       hit;
		logic [4:0] hit_x;
		logic [4:0] hit_y;
		logic [4:0] hit_z;
		logic [1:0] normal_axis;
		logic       normal_negative;
		logic [7:0] steps_used;
	} ray_hit_t;
endpackage

/* tb/sv/voxel_ray_traversal_tb.sv */
`timescale 1ns / 1ps

module voxel_ray_traversal_tb;
	import vrt_pkg::*;
	import vrt_tb_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int N_RANDOM       = 830;
	localparam int DRAIN_CYCLES   = 800;

	logic clk;
	logic arst_n;

	vrt_item_if   item ();
	vrt_result_if result ();

	voxel_ray_traversal dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item.sink),
		.result (result.source)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Testbench copy of the occupancy grid
	bit          grid_model [0:32767];
	grid_cmd_t   cmd_queue [$];
	ray_hit_t    hit_queue [$];
	int          n_fail;
	int          n_rays;
	int          n_hits;
	int          n_writes;
	bit          stim_done;
	bit          hold_sender;
	bit          long_gaps;

	// Gap length: mostly 0, sometimes short, rarely long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (!long_gaps || r < 55)
			return 0;
		else if (r < 93)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 40);
	endfunction

	// Model lookup of one cell; cells outside the grid read as empty
	function automatic bit cell_solid(int x, int y, int z);
		if (x < 0 || x >= GRID_SIZE || y < 0 || y >= GRID_SIZE || z < 0 || z >= GRID_SIZE)
			return 1'b0;
		return grid_model[(z << (2 * GRID_BITS)) | (y << GRID_BITS) | x];
	endfunction

	function automatic longint unsigned clamp_time(longint unsigned t);
		return (t > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : t;
	endfunction

	// Amanatides-Woo walk; returns the expected transaction for one ray
	function automatic ray_hit_t trace_ray(grid_cmd_t c);
		ray_hit_t         r;
		int               cpos [3];
		int               stp  [3];
		longint unsigned  tnext [3];
		longint unsigned  tstep [3];
		int               o, d, one, frac, ax, used;
		longint unsigned  mag;
		one = 1 << ORIGIN_FRAC_BITS;
		for (int k = 0; k < 3; k++) begin
			o = (k == 0) ? c.origin_x : (k == 1) ? c.origin_y : c.origin_z;
			d = (k == 0) ? c.dir_x : (k == 1) ? c.dir_y : c.dir_z;
			cpos[k] = o >>> ORIGIN_FRAC_BITS;   // floor
			frac = o - cpos[k] * one;
			if (d == 0) begin
				stp[k]   = 0;
				tnext[k] = 64'hFFFF_FFFF;
				tstep[k] = 64'hFFFF_FFFF;
			end else begin
				mag = (d > 0) ? d : -d;
				stp[k] = (d > 0) ? 1 : -1;
				if (d > 0)
					tnext[k] = clamp_time((longint'(one - frac) << DIV_SHIFT) / mag);
				else
					tnext[k] = clamp_time((longint'(frac) << DIV_SHIFT) / mag);
				tstep[k] = clamp_time((64'd1 << 30) / mag);
			end
		end
		r.hit = 1'b0;
		r.normal_axis = AXIS_NONE;
		r.normal_negative = 1'b0;
		used = 0;
		while (used < c.max_steps) begin
			used++;
			if (cell_solid(cpos[0], cpos[1], cpos[2])) begin
				r.hit = 1'b1;
				break;
			end
			// strict minimum; ties fall to the later axis (Y over X, Z over X and Y)
			if (tnext[0] < tnext[1] && tnext[0] < tnext[2])
				ax = 0;
			else if (tnext[1] < tnext[2])
				ax = 1;
			else
				ax = 2;
			cpos[ax] += stp[ax];
			tnext[ax] = clamp_time(tnext[ax] + tstep[ax]);
			r.normal_axis = ax[1:0];
			r.normal_negative = (stp[ax] > 0);
		end
		r.hit_x = r.hit ? cpos[0][4:0] : 5'd0;
		r.hit_y = r.hit ? cpos[1][4:0] : 5'd0;
		r.hit_z = r.hit ? cpos[2][4:0] : 5'd0;
		r.steps_used = used[7:0];
		return r;
	endfunction

	function automatic grid_cmd_t voxel_write(int x, int y, int z, bit s);
		grid_cmd_t c;
		c = '{default: '0};
		c.op = OP_WRITE;
		c.voxel_x = 5'(x);
		c.voxel_y = 5'(y);
		c.voxel_z = 5'(z);
		c.solid = s;
		c.origin_x = 16'($urandom);   // ignored fields still wiggle
		c.dir_z = 16'($urandom);
		return c;
	endfunction

	function automatic grid_cmd_t ray_cmd(int ox, int oy, int oz, int dx, int dy, int dz,
			int steps);
		grid_cmd_t c;
		c = '{default: '0};
		c.op = OP_RAY;
		c.voxel_x = 5'($urandom);
		c.voxel_y = 5'($urandom);
		c.voxel_z = 5'($urandom);
		c.solid = 1'($urandom);
		c.origin_x = 16'(ox);
		c.origin_y = 16'(oy);
		c.origin_z = 16'(oz);
		c.dir_x = 16'(dx);
		c.dir_y = 16'(dy);
		c.dir_z = 16'(dz);
		c.max_steps = 8'(steps);
		return c;
	endfunction

	// Origin mostly near or inside the grid, sometimes anywhere
	function automatic int rand_origin();
		if ($urandom_range(0, 9) == 0)
			return $signed(16'($urandom));
		return $urandom_range(0, 40 * 1024) - 4 * 1024;
	endfunction

	function automatic int rand_dir();
		int r;
		r = $urandom_range(0, 19);
		if (r == 0)
			return 0;
		if (r == 1)
			return -32768;
		if (r == 2)
			return ($urandom_range(0, 1) != 0) ? 16384 : -16384;
		if (r == 3)
			return $signed(16'($urandom));
		if (r < 6)
			return $urandom_range(0, 40) - 20;   // tiny: huge times, saturation
		return $urandom_range(0, 32768) - 16384;
	endfunction

	function automatic grid_cmd_t rand_ray();
		int steps;
		steps = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 80);
		return ray_cmd(rand_origin(), rand_origin(), rand_origin(), rand_dir(), rand_dir(),
			rand_dir(), steps);
	endfunction

	// Acceptance seen at the rising edge, used by the driver on its falling edge
	bit item_taken;
	always @(posedge clk) begin
		item_taken <= item.valid && item.ready;
	end

	// Driver: one transaction at a time, inputs move on the falling edge
	int drv_gap;
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item.valid <= 1'b0;
			drv_gap = 0;
		end else begin
			if (item.valid && item_taken) begin
				// accepted at the last rising edge: predict now, in order
				if (item.op == OP_WRITE) begin
					grid_model[{item.voxel_z, item.voxel_y, item.voxel_x}] = item.solid;
					n_writes++;
				end else begin
					hit_queue.push_back(trace_ray(cmd_queue[0]));
					n_rays++;
				end
				void'(cmd_queue.pop_front());
				drv_gap = pick_gap();
			end
			if (item.valid && !item_taken) begin
				// holding
			end else if (drv_gap > 0) begin
				drv_gap--;
				item.valid <= 1'b0;
			end else if (cmd_queue.size() > 0 && !hold_sender) begin
				item.valid     <= 1'b1;
				item.op        <= cmd_queue[0].op;
				item.voxel_x   <= cmd_queue[0].voxel_x;
				item.voxel_y   <= cmd_queue[0].voxel_y;
				item.voxel_z   <= cmd_queue[0].voxel_z;
				item.solid     <= cmd_queue[0].solid;
				item.origin_x  <= cmd_queue[0].origin_x;
				item.origin_y  <= cmd_queue[0].origin_y;
				item.origin_z  <= cmd_queue[0].origin_z;
				item.dir_x     <= cmd_queue[0].dir_x;
				item.dir_y     <= cmd_queue[0].dir_y;
				item.dir_z     <= cmd_queue[0].dir_z;
				item.max_steps <= cmd_queue[0].max_steps;
			end else begin
				item.valid <= 1'b0;
			end
		end
	end

	// Result side stalls
	int rdy_gap;
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result.ready <= 1'b0;
			rdy_gap = 0;
		end else if (rdy_gap > 0) begin
			rdy_gap--;
			result.ready <= 1'b0;
		end else begin
			result.ready <= 1'b1;
			rdy_gap = pick_gap();
		end
	end

	// Monitor: compare each accepted result against the oldest prediction
	ray_hit_t got;
	ray_hit_t want;
	always @(posedge clk) begin
		if (arst_n && result.valid && result.ready) begin
			got = '{result.hit, result.hit_x, result.hit_y, result.hit_z,
				result.normal_axis, result.normal_negative, result.steps_used};
			if (hit_queue.size() == 0) begin
				$display("%0t: unexpected result transaction %p", $time, got);
				n_fail++;
			end else begin
				want = hit_queue.pop_front();
				if (got !== want) begin
					$display("%0t: result mismatch expected %p actual %p", $time, want, got);
					n_fail++;
				end
				if (got.hit)
					n_hits++;
			end
		end
	end

	// Watchdog: cycles with no transaction on either side
	int idle_cycles;
	always @(posedge clk) begin
		if (!arst_n || (item.valid && item.ready) || (result.valid && result.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog expired at %0t", $time);
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		int drained;
		n_fail = 0;
		n_rays = 0;
		n_hits = 0;
		n_writes = 0;
		stim_done = 1'b0;
		hold_sender = 1'b0;
		long_gaps = 1'b0;
		foreach (grid_model[i])
			grid_model[i] = 1'b0;
		item.valid = 1'b0;
		item.op = OP_WRITE;
		item.voxel_x = '0;
		item.voxel_y = '0;
		item.voxel_z = '0;
		item.solid = 1'b0;
		item.origin_x = '0;
		item.origin_y = '0;
		item.origin_z = '0;
		item.dir_x = '0;
		item.dir_y = '0;
		item.dir_z = '0;
		item.max_steps = '0;
		result.ready = 1'b0;
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		arst_n = 1'b1;

		// Directed part
		// empty grid, straight +x ray over the whole grid
		cmd_queue.push_back(ray_cmd(512, 512, 512, 16384, 0, 0, 40));
		// corner voxels and a target on the +x path
		cmd_queue.push_back(voxel_write(31, 31, 31, 1'b1));
		cmd_queue.push_back(voxel_write(0, 0, 0, 1'b1));
		cmd_queue.push_back(voxel_write(10, 0, 0, 1'b1));
		cmd_queue.push_back(ray_cmd(512, 512, 512, 16384, 0, 0, 40));
		// start inside a solid cell: hit with no step, normal none
		cmd_queue.push_back(ray_cmd(100, 100, 100, 16384, 16384, 16384, 5));
		// zero max steps
		cmd_queue.push_back(ray_cmd(100, 100, 100, 16384, 0, 0, 0));
		// all directions zero: stays put, normal z, not negative
		cmd_queue.push_back(ray_cmd(5000, 5000, 5000, 0, 0, 0, 7));
		// ray from outside the grid walking away along -x, -y, -z
		cmd_queue.push_back(ray_cmd(-32768, -32768, -32768, -32768, -16384, -1, 255));
		cmd_queue.push_back(ray_cmd(32767, 32767, 32767, -16384, -16384, -16384, 255));
		// equal crossings: ties go to the later axis (y over x, z over x and y)
		cmd_queue.push_back(ray_cmd(512, 512, 512, 16384, 16384, 16384, 6));
		cmd_queue.push_back(ray_cmd(512, 512, 512, 16384, 16384, 0, 6));
		// tiny direction; the ray starts in the solid corner cell, so it hits before any step
		cmd_queue.push_back(ray_cmd(0, 0, 0, 1, -1, 0, 255));
		// clear a voxel, then fire at it again
		cmd_queue.push_back(voxel_write(10, 0, 0, 1'b0));
		cmd_queue.push_back(ray_cmd(512, 512, 512, 16384, 0, 0, 20));
		cmd_queue.push_back(voxel_write(31, 31, 31, 1'b0));
		cmd_queue.push_back(ray_cmd(-1, 32767, -1, 16383, -16383, 8191, 200));

		wait (cmd_queue.size() == 0);
		long_gaps = 1'b1;

		// Random part: random voxel writes, mostly solid, mixed with random rays
		for (int i = 0; i < N_RANDOM; i++) begin
			if ($urandom_range(0, 2) == 0)
				cmd_queue.push_back(voxel_write($urandom, $urandom, $urandom,
					$urandom_range(0, 3) != 0));
			else
				cmd_queue.push_back(rand_ray());
			// sender waits for every expected result once midway
			if (i == N_RANDOM / 2) begin
				wait (cmd_queue.size() == 0);
				hold_sender = 1'b1;
				wait (hit_queue.size() == 0);
				hold_sender = 1'b0;
			end
			if (i == N_RANDOM / 4) begin
				wait (cmd_queue.size() == 0);
				long_gaps = 1'b0;   // stretch with no idling
			end
			if (i == N_RANDOM / 4 + 60)
				long_gaps = 1'b1;
			if (cmd_queue.size() > 20)
				wait (cmd_queue.size() < 5);
		end
		wait (cmd_queue.size() == 0);
		stim_done = 1'b1;

		drained = 0;
		while (hit_queue.size() != 0 && drained < 100000) begin
			@(posedge clk);
			drained++;
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d voxel writes and %0d rays, %0d rays hit a solid cell",
			n_writes, n_rays, n_hits);
		if (n_fail == 0 && hit_queue.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("%0d failures, %0d results never arrived", n_fail, hit_queue.size());
			$display("simulation failed");
		end
		$finish;
	end

endmodule

/* files.f */
sv/vrt_pkg.sv
sv/vrt_if.sv
sv/vrt_ram.sv
sv/vrt_div.sv
sv/voxel_ray_traversal.sv
tb/sv/voxel_ray_traversal_tb_if.sv
tb/sv/voxel_ray_traversal_tb.sv
